### design/osg_pkg.sv
`timescale 1ns / 1ps

package osg_pkg;

  localparam logic [15:0] SYNC_MIN_RESET = 16'd2250;
  localparam logic [15:0] SYNC_MAX_RESET = 16'd6750;

  localparam logic [15:0] BAND_LOW  = 16'd2200;
  localparam logic [15:0] BAND_HIGH = 16'd6500;
  localparam logic [15:0] BAND_EDGE [0:6] = '{16'd3000, 16'd3500, 16'd4000, 16'd4500,
                                             16'd5000, 16'd5500, 16'd6000};

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Quotient bits produced by the divider; the width quotient needs only half of them.
  localparam int DIV_STEPS = 32;
  localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

  // APB register decode, on paddr[2]
  localparam int ADDR_W = 3;
  localparam logic REG_SYNC_MIN = 1'b0;
  localparam logic REG_SYNC_MAX = 1'b1;

  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic out_free;
  } dp_status_t;

  // Number of band edges at or below w: 0 for 2200..2999, up to 7 for 6000..6499.
  function automatic logic [2:0] band_code(input logic [15:0] w);
    logic [2:0] code;
    code = '0;
    for (int i = 0; i < 7; i++) begin
      if (w >= BAND_EDGE[i]) begin
        code = code + 3'd1;
      end
    end
    return code;
  endfunction

endpackage

### design/osg_div.sv
`timescale 1ns / 1ps

module osg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] time_sum,
  input  logic [31:0] width_sum,
  input  logic [15:0] count,
  output logic        busy,
  output logic [31:0] avg_time,
  output logic [15:0] avg_width
);
  import osg_pkg::*;

  logic [15:0] half;
  logic [47:0] t_div;
  logic [31:0] w_div;
  logic [15:0] t_rem;
  logic [31:0] t_q;
  logic [15:0] w_rem;
  logic [15:0] w_q;
  logic [4:0]  step;
  logic [16:0] t_trial;
  logic [16:0] w_trial;
  logic        t_ge;
  logic        w_ge;
  logic [15:0] t_rem_next;
  logic [15:0] w_rem_next;

  // Rounded division: (sum + n/2) / n. The quotients are known to fit, so the
  // upper part of each dividend starts out as the remainder.
  assign half  = {1'b0, count[15:1]};
  assign t_div = time_sum + {32'd0, half};
  assign w_div = width_sum + {16'd0, half};

  assign t_trial    = {t_rem, t_q[31]};
  assign w_trial    = {w_rem, w_q[15]};
  assign t_ge       = t_trial >= {1'b0, count};
  assign w_ge       = w_trial >= {1'b0, count};
  assign t_rem_next = t_ge ? 16'(t_trial - {1'b0, count}) : t_trial[15:0];
  assign w_rem_next = w_ge ? 16'(w_trial - {1'b0, count}) : w_trial[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 5'd1;
      if (step == DIV_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_rem <= t_div[47:32];
      t_q   <= t_div[31:0];
      w_rem <= w_div[31:16];
      w_q   <= w_div[15:0];
    end else if (busy) begin
      t_rem <= t_rem_next;
      t_q   <= {t_q[30:0], t_ge};
      if (!step[4]) begin
        w_rem <= w_rem_next;
        w_q   <= {w_q[14:0], w_ge};
      end
    end
  end

  assign avg_time  = t_q;
  assign avg_width = w_q;

endmodule

### design/osg_dp.sv
`timescale 1ns / 1ps

module osg_dp (
  input  logic               clk,
  input  logic               rst,
  input  osg_pkg::dp_cmd_t    cmd,
  output osg_pkg::dp_status_t status,
  input  logic [15:0]        sync_min,
  input  logic [15:0]        sync_max,
  input  logic [31:0]        pulse_time,
  input  logic [15:0]        pulse_width,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               is_sync,
  output logic               group_closed,
  output logic [31:0]        group_time,
  output logic [15:0]        group_width,
  output logic [2:0]         group_code,
  output logic               code_valid
);
  import osg_pkg::*;

  logic [31:0] cur_t;
  logic [15:0] cur_w;
  logic [47:0] time_sum;
  logic [31:0] width_sum;
  logic [15:0] group_count;
  logic        prev_sync;

  logic        div_busy;
  logic [31:0] avg_t;
  logic [15:0] avg_w;

  logic        sync;
  logic        open_group;
  logic [32:0] a_end;
  logic [32:0] b_end;
  logic [15:0] ov;
  logic        overlap;
  logic        joins;
  logic        closed;
  logic        band_ok;

  osg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .time_sum  (time_sum),
    .width_sum (width_sum),
    .count     (group_count),
    .busy      (div_busy),
    .avg_time  (avg_t),
    .avg_width (avg_w)
  );

  assign sync       = (cur_w >= sync_min) && (cur_w <= sync_max);
  assign open_group = prev_sync && (group_count != '0);

  assign a_end = {1'b0, avg_t} + {17'd0, avg_w};
  assign b_end = {1'b0, cur_t} + {17'd0, cur_w};

  // Overlap length is below the width of the earlier-starting pulse, so 16 bits hold it.
  always_comb begin
    ov = '0;
    if ((avg_t < cur_t) && (a_end > {1'b0, cur_t})) begin
      ov = 16'(a_end - {1'b0, cur_t});
    end else if ((cur_t < avg_t) && (b_end > {1'b0, avg_t})) begin
      ov = 16'(b_end - {1'b0, avg_t});
    end
  end

  assign overlap = ov > {1'b0, avg_w[15:1]};
  assign joins   = sync && open_group && overlap;
  assign closed  = open_group && !joins;
  assign band_ok = (avg_w >= BAND_LOW) && (avg_w < BAND_HIGH);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_t <= pulse_time;
      cur_w <= pulse_width;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_sum    <= '0;
      width_sum   <= '0;
      group_count <= '0;
      prev_sync   <= 1'b0;
    end else if (cmd.commit) begin
      prev_sync <= sync;
      if (sync) begin
        if (!joins) begin
          time_sum    <= {16'd0, cur_t};
          width_sum   <= {16'd0, cur_w};
          group_count <= 16'd1;
        end else if (group_count != COUNT_MAX) begin
          time_sum    <= time_sum + {16'd0, cur_t};
          width_sum   <= width_sum + {16'd0, cur_w};
          group_count <= group_count + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      is_sync      <= sync;
      group_closed <= closed;
      group_time   <= closed ? avg_t : '0;
      group_width  <= closed ? avg_w : '0;
      group_code   <= (closed && band_ok) ? band_code(avg_w) : '0;
      code_valid   <= closed && band_ok;
    end
  end

  assign status.need_div = open_group;
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || !out_stall;

  a_open_has_count: assert property (@(posedge clk) disable iff (rst)
    prev_sync |-> group_count != '0)
    else $error("sync flag set with an empty group");

  a_join_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && joins && group_count != COUNT_MAX) |=>
      group_count == $past(group_count) + 16'd1)
    else $error("joining pulse did not advance the group count");

endmodule

### design/osg_ctrl.sv
`timescale 1ns / 1ps

module osg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  osg_pkg::dp_status_t status,
  output osg_pkg::dp_cmd_t    cmd
);
  import osg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.need_div) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else begin
            state_next = S_DEC;
          end
        end
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        // hold the decision until the output register can take it
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  a_div_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && status.need_div) |=> status.div_busy)
    else $error("divider did not start for an open group");

  a_busy_in_div: assert property (@(posedge clk) disable iff (rst)
    status.div_busy |-> state == S_DIV)
    else $error("divider running outside the divide state");

endmodule

### design/optical_sync_pulse_grouper.sv
`timescale 1ns / 1ps
// Optical sync pulse grouper.
// Input channel (in_valid / in_stall): one light pulse per transaction,
// pulse_time and pulse_width. Output channel (out_valid / out_stall): one
// result transaction per pulse: is_sync, and when a sync group closed,
// group_closed with the group's rounded average time, width and band code.
// Sync window limits are written over the APB port (0x0 min, 0x4 max); the
// user must write them only while the block is idle, as the block does not
// enforce it. pready is always high. With an open sync group the averages
// come from a shift-subtract divider producing one quotient bit per cycle;
// the pulse passes the idle, divide and decision states, and without an open
// group it skips the divide state. The result is registered on commit, and
// in_stall stays high until then, so the next pulse waits for that commit.
// The output register lets a new pulse be accepted while a result waits;
// if out_stall is still high when the next result is ready, the block holds
// that result and keeps in_stall high until the output register frees.
// Reset (synchronous, rst high) clears the group state and restores the
// window limits to 2250 and 6750.
module optical_sync_pulse_grouper (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                pulse_time,
  input  logic [15:0]                pulse_width,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       is_sync,
  output logic                       group_closed,
  output logic [31:0]                group_time,
  output logic [15:0]                group_width,
  output logic [2:0]                 group_code,
  output logic                       code_valid,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [osg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import osg_pkg::*;

  logic [15:0] sync_min;
  logic [15:0] sync_max;
  logic        cfg_wr;
  dp_cmd_t     cmd;
  dp_status_t  status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_min <= SYNC_MIN_RESET;
      sync_max <= SYNC_MAX_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SYNC_MIN) begin
        sync_min <= pwdata[15:0];
      end else begin
        sync_max <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SYNC_MAX) ? {16'd0, sync_max} : {16'd0, sync_min};

  osg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  osg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sync_min     (sync_min),
    .sync_max     (sync_max),
    .pulse_time   (pulse_time),
    .pulse_width  (pulse_width),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .is_sync      (is_sync),
    .group_closed (group_closed),
    .group_time   (group_time),
    .group_width  (group_width),
    .group_code   (group_code),
    .code_valid   (code_valid)
  );

endmodule
